FILE: hw/rtl/gregorian_date_up_down_counter_defines.svh
// Assertion macros for the Gregorian date counter.
// Used by the top level only; no other dependencies.
`ifndef GREGORIAN_DATE_UP_DOWN_COUNTER_DEFINES_SVH
`define GREGORIAN_DATE_UP_DOWN_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define GDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define GDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/gdc_pkg.sv
// Package for the Gregorian date counter: mode codes, date type and
// calendar helper functions. No dependencies.
package gdc_pkg;

    localparam int MonthW = 4;
    localparam int DayW   = 5;
    localparam int YearW  = 12;

    localparam logic [YearW-1:0]  YEAR_MIN  = YearW'(1600);
    localparam logic [YearW-1:0]  YEAR_MAX  = YearW'(2100);
    localparam logic [MonthW-1:0] MONTH_JAN = MonthW'(1);
    localparam logic [MonthW-1:0] MONTH_FEB = MonthW'(2);
    localparam logic [MonthW-1:0] MONTH_DEC = MonthW'(12);
    localparam logic [DayW-1:0]   DAY_ONE   = DayW'(1);
    localparam logic [DayW-1:0]   DAY_MAX   = DayW'(31);

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_NEXT = 2'd1,
        MODE_PREV = 2'd2,
        MODE_HOLD = 2'd3
    } mode_t;

    typedef struct packed {
        logic [YearW-1:0]  year;
        logic [DayW-1:0]   day;
        logic [MonthW-1:0] month;
    } date_t;

    // Leap rule for years already clamped to 1600..2100: only 1600 and
    // 2000 are multiples of 400, the other centuries are plain years.
    function automatic logic is_leap(input logic [YearW-1:0] y);
        logic century;
        begin
            century = (y == YearW'(1700)) || (y == YearW'(1800)) ||
                      (y == YearW'(1900)) || (y == YearW'(2100));
            is_leap = (y[1:0] == 2'b00) && !century;
        end
    endfunction

    // Days in month m of year y
    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                  input logic [YearW-1:0]  y);
        begin
            case (m)
                MONTH_FEB:                           month_len = is_leap(y) ? DayW'(29)
                                                                            : DayW'(28);
                MonthW'(4), MonthW'(6),
                MonthW'(9), MonthW'(11):             month_len = DayW'(30);
                default:                             month_len = DAY_MAX;
            endcase
        end
    endfunction

    // Clamp year, month and day to range, then cut day to month length
    function automatic date_t clamp_date(input logic [MonthW-1:0] m,
                                         input logic [DayW-1:0]   d,
                                         input logic [YearW-1:0]  y);
        date_t            r;
        logic [DayW-1:0]  len;
        begin
            r.year  = (y < YEAR_MIN) ? YEAR_MIN : ((y > YEAR_MAX) ? YEAR_MAX : y);
            r.month = (m < MONTH_JAN) ? MONTH_JAN : ((m > MONTH_DEC) ? MONTH_DEC : m);
            r.day   = (d < DAY_ONE) ? DAY_ONE : d;
            len     = month_len(r.month, r.year);
            if (r.day > len)
            begin
                r.day = len;
            end
            clamp_date = r;
        end
    endfunction

endpackage

FILE: hw/rtl/gregorian_date_up_down_counter.sv
// Top level of the Gregorian date up/down counter.
// Depends on gdc_pkg and gregorian_date_up_down_counter_defines.svh.

// Keeps a calendar date (1600-01-01 after reset) and applies one operation
// per item taken on the slave stream: load with clamping, next day, previous
// day, or hold (mode 3). Every item returns the date after its operation on
// the master stream. The block takes one item per cycle while results are
// taken. An item taken passes from the input register into the date registers,
// which also serve as the output register. A stalled result holds the date
// registers and, once the input register is also full, holds off the slave
// stream. The per-item update is combinational logic feeding back into the
// date registers.
`include "gregorian_date_up_down_counter_defines.svh"

module gregorian_date_up_down_counter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [3:0] load_month, [8:4] load_day, [20:9] load_year, pad
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [3:0] cur_month, [8:4] cur_day, [20:9] cur_year, pad
);

    // Input register
    logic                          in_valid_reg;
    gdc_pkg::mode_t                in_mode_reg;
    logic [gdc_pkg::MonthW-1:0]    in_month_reg;
    logic [gdc_pkg::DayW-1:0]      in_day_reg;
    logic [gdc_pkg::YearW-1:0]     in_year_reg;

    // Date state, doubles as the result register
    gdc_pkg::date_t                date_reg;
    gdc_pkg::date_t                date_next;
    logic                          out_valid_reg;

    logic                          advance;
    logic [gdc_pkg::DayW-1:0]      cur_len;
    logic [gdc_pkg::MonthW-1:0]    prev_month;

    // Stage moves when the result slot is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_mode_reg  <= gdc_pkg::mode_t'(s_tuser);
            in_month_reg <= s_tdata[3:0];
            in_day_reg   <= s_tdata[8:4];
            in_year_reg  <= s_tdata[20:9];
        end
    end

    // Date update for the item in the input register
    always_comb
    begin
        cur_len    = gdc_pkg::month_len(date_reg.month, date_reg.year);
        prev_month = date_reg.month - 4'd1;
        date_next  = date_reg;
        case (in_mode_reg)
            gdc_pkg::MODE_LOAD:
            begin
                date_next = gdc_pkg::clamp_date(in_month_reg, in_day_reg, in_year_reg);
            end
            gdc_pkg::MODE_NEXT:
            begin
                if (date_reg.day < cur_len)
                begin
                    date_next.day = date_reg.day + 5'd1;
                end
                else if (date_reg.month >= gdc_pkg::MONTH_DEC)
                begin
                    date_next = gdc_pkg::clamp_date(gdc_pkg::MONTH_JAN, gdc_pkg::DAY_ONE,
                                                    date_reg.year + 12'd1);
                end
                else
                begin
                    date_next = gdc_pkg::clamp_date(date_reg.month + 4'd1, gdc_pkg::DAY_ONE,
                                                    date_reg.year);
                end
            end
            gdc_pkg::MODE_PREV:
            begin
                if (date_reg.day > gdc_pkg::DAY_ONE)
                begin
                    date_next.day = date_reg.day - 5'd1;
                end
                else if (date_reg.month <= gdc_pkg::MONTH_JAN)
                begin
                    date_next = gdc_pkg::clamp_date(gdc_pkg::MONTH_DEC, gdc_pkg::DAY_MAX,
                                                    date_reg.year - 12'd1);
                end
                else
                begin
                    date_next = gdc_pkg::clamp_date(prev_month,
                                    gdc_pkg::month_len(prev_month, date_reg.year),
                                    date_reg.year);
                end
            end
            default:
            begin
                date_next = date_reg;
            end
        endcase
    end

    // Date registers and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            date_reg      <= '{year: gdc_pkg::YEAR_MIN, day: gdc_pkg::DAY_ONE,
                               month: gdc_pkg::MONTH_JAN};
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                date_reg <= date_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, date_reg.year, date_reg.day, date_reg.month};

    // Checks
    `GDC_ASSERT_NOW(a_day_fits_month, clk, rst_n, m_tvalid,
        (date_reg.day >= gdc_pkg::DAY_ONE) &&
        (date_reg.day <= gdc_pkg::month_len(date_reg.month, date_reg.year)),
        "result day outside its month")
    `GDC_ASSERT_NOW(a_stall_blocks_input, clk, rst_n,
        in_valid_reg && out_valid_reg && !m_tready, !s_tready,
        "input taken while pipeline is full")
    `GDC_ASSERT_NEXT(a_item_reaches_output, clk, rst_n, in_valid_reg && advance,
        m_tvalid, "item lost between input register and result")

endmodule

FILE: dv/tb_top.sv
// Testbench for the Gregorian date up/down counter: directed and random
// date operations, checked item by item against a calendar predictor.
// Depends on gdc_pkg and the gregorian_date_up_down_counter top level.
module tb_top;

    localparam int CLK_HALF       = 4;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int IDLE_PCT       = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TX_PAUSE_AT    = 600;
    localparam int RX_HOLD_AT     = 900;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int BURST_FIRST    = 1200;
    localparam int BURST_LAST     = 1500;

    // Calendar predictor plus the queue of dates still owed by the block
    class date_scoreboard;
        int    cur_month = 1;
        int    cur_day   = 1;
        int    cur_year  = 1600;
        gdc_pkg::date_t expected_dates[$];
        int unsigned mismatch_count = 0;

        function bit leap_year(int y);
            return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
        endfunction

        function int days_in_month(int m, int y);
            if (m == 2)
            begin
                return leap_year(y) ? 29 : 28;
            end
            if (m == 4 || m == 6 || m == 9 || m == 11)
            begin
                return 30;
            end
            return 31;
        endfunction

        // Clamp each field to range, then cut the day to the month length
        function void load_clamped(int m, int d, int y);
            int len;
            cur_year  = (y < 1600) ? 1600 : ((y > 2100) ? 2100 : y);
            cur_month = (m < 1) ? 1 : ((m > 12) ? 12 : m);
            cur_day   = (d < 1) ? 1 : ((d > 31) ? 31 : d);
            len = days_in_month(cur_month, cur_year);
            if (cur_day > len)
            begin
                cur_day = len;
            end
        endfunction

        // Apply one accepted item and queue the date it yields
        function void note_input(gdc_pkg::mode_t mode, logic [3:0] m, logic [4:0] d,
                                 logic [11:0] y);
            gdc_pkg::date_t want;
            case (mode)
                gdc_pkg::MODE_LOAD: load_clamped(int'(m), int'(d), int'(y));
                gdc_pkg::MODE_NEXT:
                begin
                    if (cur_day < days_in_month(cur_month, cur_year))
                        cur_day = cur_day + 1;
                    else if (cur_month >= 12)
                        load_clamped(1, 1, cur_year + 1);
                    else
                        load_clamped(cur_month + 1, 1, cur_year);
                end
                gdc_pkg::MODE_PREV:
                begin
                    if (cur_day > 1)
                        cur_day = cur_day - 1;
                    else if (cur_month <= 1)
                        load_clamped(12, 31, cur_year - 1);
                    else
                        load_clamped(cur_month - 1,
                                     days_in_month(cur_month - 1, cur_year), cur_year);
                end
                default: ;
            endcase
            want.month = cur_month[3:0];
            want.day   = cur_day[4:0];
            want.year  = cur_year[11:0];
            expected_dates.push_back(want);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            mismatch_count++;
        endtask

        // Compare one result item with the oldest queued date
        task check_result(logic [23:0] data);
            gdc_pkg::date_t got;
            gdc_pkg::date_t want;
            got.month = data[3:0];
            got.day   = data[8:4];
            got.year  = data[20:9];
            if (expected_dates.size() == 0)
            begin
                report($sformatf("result %0d-%0d-%0d with nothing expected",
                                 got.year, got.month, got.day));
            end
            else
            begin
                want = expected_dates.pop_front();
                if (got.month !== want.month)
                    report($sformatf("cur_month %0d, expected %0d", got.month, want.month));
                if (got.day !== want.day)
                    report($sformatf("cur_day %0d, expected %0d", got.day, want.day));
                if (got.year !== want.year)
                    report($sformatf("cur_year %0d, expected %0d", got.year, want.year));
            end
        endtask
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = 2'b00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    date_scoreboard sb = new;
    int unsigned    tx_count = 0;
    int unsigned    rx_count = 0;
    int unsigned    quiet_cycles = 0;

    gregorian_date_up_down_counter u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [3:0] load_month, [8:4] load_day, [20:9] load_year, pad
        .s_tuser  (s_tuser),   // [1:0] mode
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [3:0] cur_month, [8:4] cur_day, [20:9] cur_year, pad
    );

    always #CLK_HALF clk = ~clk;

    // Offer one item, with random idle cycles ahead of it, until taken
    task automatic send_item(gdc_pkg::mode_t mode, int m, int d, int y);
        logic [3:0]  fm;
        logic [4:0]  fd;
        logic [11:0] fy;
        bit          burst;
        fm    = m[3:0];
        fd    = d[4:0];
        fy    = y[11:0];
        burst = (tx_count >= BURST_FIRST) && (tx_count < BURST_LAST);
        while (!burst && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, fy, fd, fm};
        s_tuser  <= mode;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sb.note_input(mode, fm, fd, fy);
        tx_count++;
    endtask

    // Non-load item: the load fields carry random junk
    task automatic send_step(gdc_pkg::mode_t mode);
        send_item(mode, $urandom_range(15), $urandom_range(31), $urandom_range(4095));
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_dates.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Field extremes, leap rules, month cuts, year wrap at both ends
    task automatic run_directed();
        send_step(gdc_pkg::MODE_HOLD);                    // reset date
        send_step(gdc_pkg::MODE_PREV);                    // underflow below 1600
        send_step(gdc_pkg::MODE_NEXT);
        send_item(gdc_pkg::MODE_LOAD, 0, 0, 0);
        send_item(gdc_pkg::MODE_LOAD, 15, 31, 4095);
        send_step(gdc_pkg::MODE_NEXT);                    // overflow past 2100
        send_item(gdc_pkg::MODE_LOAD, 2, 29, 2000);
        send_step(gdc_pkg::MODE_NEXT);
        send_step(gdc_pkg::MODE_PREV);
        send_item(gdc_pkg::MODE_LOAD, 2, 31, 1900);       // century, not leap
        send_item(gdc_pkg::MODE_LOAD, 2, 30, 2100);
        send_item(gdc_pkg::MODE_LOAD, 2, 31, 1600);       // multiple of 400
        send_item(gdc_pkg::MODE_LOAD, 2, 29, 2023);
        send_item(gdc_pkg::MODE_LOAD, 2, 31, 2024);
        send_item(gdc_pkg::MODE_LOAD, 4, 31, 1999);
        send_item(gdc_pkg::MODE_LOAD, 6, 31, 1999);
        send_item(gdc_pkg::MODE_LOAD, 9, 31, 1999);
        send_item(gdc_pkg::MODE_LOAD, 11, 31, 1999);
        send_step(gdc_pkg::MODE_NEXT);
        send_step(gdc_pkg::MODE_PREV);
        send_item(gdc_pkg::MODE_LOAD, 13, 15, 1599);
        send_item(gdc_pkg::MODE_LOAD, 7, 0, 2101);
        send_item(gdc_pkg::MODE_HOLD, 15, 31, 4095);      // load fields ignored
        send_item(gdc_pkg::MODE_LOAD, 1, 1, 1600);
        send_step(gdc_pkg::MODE_PREV);
    endtask

    // Mostly day walks from loads near month ends, plus raw loads and holds
    task automatic run_random();
        int unsigned    sent;
        int unsigned    pick;
        int unsigned    run_len;
        int             year_pick;
        bit             paused;
        gdc_pkg::mode_t dir;
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            if (!paused && tx_count >= TX_PAUSE_AT)
            begin
                paused = 1'b1;
                wait_for_drain();
            end
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                send_item(gdc_pkg::MODE_LOAD, $urandom_range(15), $urandom_range(31),
                          $urandom_range(4095));
                sent++;
            end
            else if (pick < 25)
            begin
                case ($urandom_range(7))
                    0:       year_pick = 1600;
                    1:       year_pick = 1700;
                    2:       year_pick = 1900;
                    3:       year_pick = 2000;
                    4:       year_pick = 2100;
                    default: year_pick = $urandom_range(2100, 1600);
                endcase
                send_item(gdc_pkg::MODE_LOAD, $urandom_range(12, 1), $urandom_range(31, 27),
                          year_pick);
                sent++;
            end
            else if (pick < 30)
            begin
                send_step(gdc_pkg::MODE_HOLD);
                sent++;
            end
            else
            begin
                run_len = $urandom_range(40, 1);
                if (pick[0])
                    dir = gdc_pkg::MODE_NEXT;
                else
                    dir = gdc_pkg::MODE_PREV;
                repeat (run_len)
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        if (dir == gdc_pkg::MODE_NEXT)
                            dir = gdc_pkg::MODE_PREV;
                        else
                            dir = gdc_pkg::MODE_NEXT;
                    end
                    send_step(dir);
                    sent++;
                end
            end
        end
    endtask

    // Stimulus and end of run
    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.expected_dates.size() == 0)
            $display("** gregorian_date_up_down_counter: PASSED **");
        else
            $display("** gregorian_date_up_down_counter: FAILED **");
        $finish;
    end

    // Result side: random back-pressure, one long hold-off, then checking
    initial
    begin : result_sink
        bit held;
        bit burst;
        held = 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (!held && rx_count >= RX_HOLD_AT)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            burst = (rx_count >= BURST_FIRST) && (rx_count < BURST_LAST);
            m_tready <= burst || ($urandom_range(99) >= IDLE_PCT);
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                sb.check_result(m_tdata);
                rx_count++;
            end
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** gregorian_date_up_down_counter: FAILED **");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
